// ===== hdl/msort_pkg.sv =====
package msort_pkg;

    localparam int VALUE_W       = 31;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               final_req;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               duplicate_error;
        logic               overflow;
        logic               last_out;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_ERR
    } t_state;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT,
        CMD_CLEAR
    } t_cell_cmd;

    // what one cell shows to its neighbours
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               gt;
    } t_cell_link;

endpackage

// ===== hdl/msort_cell.sv =====
module msort_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  msort_pkg::t_cell_cmd             i_cmd,
    input  logic [msort_pkg::VALUE_W-1:0]    i_value,
    input  msort_pkg::t_cell_link            i_left,
    input  msort_pkg::t_cell_link            i_right,
    output msort_pkg::t_cell_link            o_link,
    output logic                             o_match
);
    import msort_pkg::*;

    logic               r_valid;
    logic               n_valid;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               w_gt;

    assign w_gt    = r_valid && (r_value > i_value);
    assign o_match = r_valid && (r_value == i_value);
    assign o_link  = '{valid: r_valid, value: r_value, gt: w_gt};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        unique case (i_cmd)
            CMD_HOLD: begin
            end
            CMD_INSERT: begin
                if (i_left.gt) begin
                    // everything from here up moves one place right
                    n_valid = 1'b1;
                    n_value = i_left.value;
                end else if (i_left.valid && (!r_valid || w_gt)) begin
                    n_valid = 1'b1;
                    n_value = i_value;
                end
            end
            CMD_SHIFT: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
            end
            CMD_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== hdl/merge_insertion_sorter.sv =====
// Sorts a list of up to MAX_ITEMS distinct 31-bit values held in a row of
// insertion cells, one cell per stored value. While a list loads, one value
// is taken every cycle: the new value is broadcast to all cells, each cell
// compares it with its own value, and the row shifts right from the
// insertion point in that same cycle. A repeated value is flagged and not
// stored; values beyond MAX_ITEMS are dropped and flag overflow. After the
// transaction carrying final_req the input stalls while the result is
// emitted: n sorted values, one per unstalled cycle, shifted out of the
// first cell via the output register, or one duplicate-error transaction.
// Loading resumes in the cycle after the last result leaves the row.
module merge_insertion_sorter #(
    parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  msort_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output msort_pkg::t_out_item o_out_data
);
    import msort_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic                  r_dup;
    logic                  n_dup;
    logic                  r_ovf;
    logic                  n_ovf;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;
    t_cell_cmd             w_cmd;
    t_cell_link            w_link  [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  w_match;
    logic [MAX_ITEMS-1:0]  w_valid;
    logic                  w_in_acc;
    logic                  w_dup_now;
    logic                  w_full;
    logic                  w_out_free;

    localparam t_cell_link LINK_HEAD = '{valid: 1'b1, value: '0, gt: 1'b0};
    localparam t_cell_link LINK_TAIL = '{valid: 1'b0, value: '0, gt: 1'b0};

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            t_cell_link w_left;
            t_cell_link w_right;
            if (g == 0) begin : g_head
                assign w_left = LINK_HEAD;
            end else begin : g_mid_l
                assign w_left = w_link[g-1];
            end
            if (g == MAX_ITEMS - 1) begin : g_tail
                assign w_right = LINK_TAIL;
            end else begin : g_mid_r
                assign w_right = w_link[g+1];
            end
            msort_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_value (i_in_data.value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[g]),
                .o_match (w_match[g])
            );
            assign w_valid[g] = w_link[g].valid;
        end
    endgenerate

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_dup_now  = |w_match;
    assign w_full     = w_valid[MAX_ITEMS-1];
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_dup       = r_dup;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_cmd       = CMD_HOLD;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    n_dup = r_dup || w_dup_now;
                    n_ovf = r_ovf || (!w_dup_now && w_full);
                    if (!w_dup_now && !w_full) begin
                        w_cmd = CMD_INSERT;
                    end
                    if (i_in_data.final_req) begin
                        n_state = n_dup ? ST_ERR : ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    w_cmd       = CMD_SHIFT;
                    n_out_valid = 1'b1;
                    n_out       = '{sorted_value:    w_link[0].value,
                                    duplicate_error: 1'b0,
                                    overflow:        r_ovf,
                                    last_out:        !w_valid[1]};
                    if (!w_valid[1]) begin
                        n_state = ST_LOAD;
                        n_dup   = 1'b0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    w_cmd       = CMD_CLEAR;
                    n_out_valid = 1'b1;
                    n_out       = '{sorted_value:    '0,
                                    duplicate_error: 1'b1,
                                    overflow:        r_ovf,
                                    last_out:        1'b1};
                    n_state     = ST_LOAD;
                    n_dup       = 1'b0;
                    n_ovf       = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_dup       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dup       <= n_dup;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTH
    // occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("cell row has a gap");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_valid[0])
        else $error("draining an empty row");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.duplicate_error) |->
        (r_out.last_out && (r_out.sorted_value == '0)))
        else $error("malformed duplicate result");

    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.final_req) |=> o_in_stall)
        else $error("input not stalled after final transaction");
`endif

endmodule
